[rtl/mfws_pkg.sv]
// Shared constants, stage timing and saturating arithmetic for the fast wave speed pipeline.
`timescale 1ns / 1ps
package mfws_pkg;

    localparam int FRAC_BITS_DEFAULT  = 16;
    localparam int WORD_WIDTH_DEFAULT = 32;
    localparam int GAMMA_WIDTH        = 18;
    localparam logic [GAMMA_WIDTH-1:0] GAMMA_RESET = 18'd109227;

    localparam logic signed [63:0] INT_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;

    // unit latencies in register stages
    localparam int MUL_LAT  = 4;
    localparam int DIV_STEPS = 63;
    localparam int DIV_LAT  = DIV_STEPS + 2;
    localparam int SQRT_STEPS = 48;
    localparam int SQRT_LAT = SQRT_STEPS + 1;

    // pipeline time points, counted from the input register
    localparam int T0  = 0;
    localparam int T1  = T0 + MUL_LAT;
    localparam int T2  = T1 + 1;
    localparam int T3  = T2 + DIV_LAT;
    localparam int T4  = T3 + 1;
    localparam int T5  = T4 + MUL_LAT;
    localparam int T6  = T5 + MUL_LAT;
    localparam int T7  = T6 + DIV_LAT;
    localparam int T8  = T7 + 1;
    localparam int T9  = T8 + MUL_LAT;
    localparam int T10 = T9 + 1;
    localparam int T11 = T10 + SQRT_LAT;
    localparam int T12 = T11 + 1;
    localparam int T13 = T12 + SQRT_LAT;
    localparam int T_OUT = T13 + 1;

    typedef struct packed {
        logic valid;
        logic last;
        logic rho_bad;
    } ctrl_t;

    function automatic logic [63:0] mag64(input logic signed [63:0] x);
        return x[63] ? 64'(-x) : 64'(x);
    endfunction

    function automatic logic signed [63:0] clamp65(input logic signed [64:0] s);
        if (s > 65'(INT_MAX))
            return INT_MAX;
        else if (s < -65'(INT_MAX))
            return -INT_MAX;
        else
            return s[63:0];
    endfunction

    function automatic logic signed [63:0] sadd(input logic signed [63:0] a,
                                                input logic signed [63:0] b);
        logic signed [64:0] s;
        s = 65'(a) + 65'(b);
        return clamp65(s);
    endfunction

    function automatic logic signed [63:0] ssub(input logic signed [63:0] a,
                                                input logic signed [63:0] b);
        logic signed [63:0] nb;
        nb = (b == {1'b1, 63'b0}) ? INT_MAX : -b;
        return sadd(a, nb);
    endfunction

    // halve, truncating toward zero
    function automatic logic signed [63:0] half(input logic signed [63:0] x);
        logic signed [63:0] t;
        t = x + 64'(x[63]);
        return t >>> 1;
    endfunction

    // two saturating doublings are one clamp of four times the value
    function automatic logic signed [63:0] times4(input logic signed [63:0] x);
        logic signed [65:0] w;
        w = 66'(x) <<< 2;
        if (w > 66'(INT_MAX))
            return INT_MAX;
        else if (w < -66'(INT_MAX))
            return -INT_MAX;
        else
            return w[63:0];
    endfunction

endpackage

[rtl/mfws_delay.sv]
// Shift-register delay line that keeps operands and control aligned with the units.
`timescale 1ns / 1ps
module mfws_delay #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 1
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic [WIDTH-1:0] d,
    output logic [WIDTH-1:0] q
);
    logic [WIDTH-1:0] tap_reg [DEPTH];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < DEPTH; k++)
                tap_reg[k] <= '0;
        end
        else
        begin
            tap_reg[0] <= d;
            for (int k = 1; k < DEPTH; k++)
                tap_reg[k] <= tap_reg[k-1];
        end
    end

    assign q = tap_reg[DEPTH-1];
endmodule

[rtl/mfws_mul.sv]
// Pipelined 64 x 64 signed fixed-point multiplier from four 32 x 32 partial products.
`timescale 1ns / 1ps
module mfws_mul #(
    parameter int FRAC_BITS = mfws_pkg::FRAC_BITS_DEFAULT
) (
    input  logic               clk,
    input  logic signed [63:0] a,
    input  logic signed [63:0] b,
    output logic signed [63:0] p
);
    import mfws_pkg::*;

    logic [63:0]  am_reg, bm_reg;
    logic         neg1_reg, neg2_reg, neg3_reg;
    logic [63:0]  p00_reg, p01_reg, p10_reg, p11_reg;
    logic [127:0] sum_reg;
    logic signed [63:0] p_reg;
    logic [127:0] sh;
    logic [63:0]  m;

    always_comb
    begin
        sh = sum_reg >> FRAC_BITS;
        m  = (|sh[127:63]) ? 64'(INT_MAX) : {1'b0, sh[62:0]};
    end

    always_ff @(posedge clk)
    begin
        am_reg   <= mag64(a);
        bm_reg   <= mag64(b);
        neg1_reg <= a[63] ^ b[63];
        p00_reg  <= 64'(am_reg[31:0])  * 64'(bm_reg[31:0]);
        p01_reg  <= 64'(am_reg[31:0])  * 64'(bm_reg[63:32]);
        p10_reg  <= 64'(am_reg[63:32]) * 64'(bm_reg[31:0]);
        p11_reg  <= 64'(am_reg[63:32]) * 64'(bm_reg[63:32]);
        neg2_reg <= neg1_reg;
        sum_reg  <= {64'b0, p00_reg} + ({64'b0, p01_reg} << 32)
                    + ({64'b0, p10_reg} << 32) + {p11_reg, 64'b0};
        neg3_reg <= neg2_reg;
        p_reg    <= neg3_reg ? -$signed(m) : $signed(m);
    end

    assign p = p_reg;
endmodule

[rtl/mfws_div.sv]
// Pipelined restoring divider: (a * 2^FRAC_BITS) / b, truncated toward zero, saturated.
`timescale 1ns / 1ps
module mfws_div #(
    parameter int FRAC_BITS = mfws_pkg::FRAC_BITS_DEFAULT
) (
    input  logic               clk,
    input  logic signed [63:0] a,
    input  logic signed [63:0] b,
    output logic signed [63:0] q
);
    import mfws_pkg::*;

    logic [63:0]          rem_reg [DIV_STEPS+1];
    logic [63:0]          den_reg [DIV_STEPS+1];
    logic [DIV_STEPS-1:0] num_reg [DIV_STEPS+1];
    logic [DIV_STEPS-1:0] quo_reg [DIV_STEPS+1];
    logic [DIV_STEPS:0]   neg_reg, ovf_reg, dz_reg;
    logic [63:0]          rem_next [DIV_STEPS];
    logic [DIV_STEPS-1:0] qbit_next;
    logic signed [63:0]   q_reg;

    logic [63:0]  m, d;
    logic [126:0] nfull;
    logic [63:0]  magq;
    logic [64:0]  trial;

    always_comb
    begin
        m     = mag64(a);
        d     = mag64(b);
        nfull = {63'b0, m} << FRAC_BITS;
    end

    always_comb
    begin
        for (int k = 0; k < DIV_STEPS; k++)
        begin
            trial = {rem_reg[k], num_reg[k][DIV_STEPS-1]};
            if (trial >= {1'b0, den_reg[k]})
            begin
                rem_next[k]  = 64'(trial - {1'b0, den_reg[k]});
                qbit_next[k] = 1'b1;
            end
            else
            begin
                rem_next[k]  = trial[63:0];
                qbit_next[k] = 1'b0;
            end
        end
    end

    always_comb
    begin
        if (dz_reg[DIV_STEPS])
            magq = '0;
        else if (ovf_reg[DIV_STEPS])
            magq = 64'(INT_MAX);
        else
            magq = {1'b0, quo_reg[DIV_STEPS]};
    end

    always_ff @(posedge clk)
    begin
        // a quotient of 2^63 or more shows up in the top numerator bits alone
        rem_reg[0] <= nfull[126:63];
        den_reg[0] <= d;
        num_reg[0] <= nfull[62:0];
        quo_reg[0] <= '0;
        neg_reg[0] <= a[63] ^ b[63];
        ovf_reg[0] <= nfull[126:63] >= d;
        dz_reg[0]  <= d == '0;
        for (int k = 0; k < DIV_STEPS; k++)
        begin
            rem_reg[k+1] <= rem_next[k];
            den_reg[k+1] <= den_reg[k];
            num_reg[k+1] <= num_reg[k] << 1;
            quo_reg[k+1] <= {quo_reg[k][DIV_STEPS-2:0], qbit_next[k]};
            neg_reg[k+1] <= neg_reg[k];
            ovf_reg[k+1] <= ovf_reg[k];
            dz_reg[k+1]  <= dz_reg[k];
        end
        q_reg <= neg_reg[DIV_STEPS] ? -$signed(magq) : $signed(magq);
    end

    assign q = q_reg;
endmodule

[rtl/mfws_sqrt.sv]
// Pipelined digit-by-digit square root: floor(sqrt(x * 2^FRAC_BITS)), zero for x <= 0.
`timescale 1ns / 1ps
module mfws_sqrt #(
    parameter int FRAC_BITS = mfws_pkg::FRAC_BITS_DEFAULT
) (
    input  logic               clk,
    input  logic signed [63:0] x,
    output logic signed [63:0] r
);
    import mfws_pkg::*;

    logic [95:0]           num_reg  [SQRT_STEPS+1];
    logic [49:0]           rem_reg  [SQRT_STEPS+1];
    logic [SQRT_STEPS-1:0] root_reg [SQRT_STEPS+1];
    logic [49:0]           rem_next [SQRT_STEPS];
    logic [SQRT_STEPS-1:0] bit_next;

    logic [51:0] cur;
    logic [51:0] trial;

    always_comb
    begin
        for (int j = 0; j < SQRT_STEPS; j++)
        begin
            cur   = {rem_reg[j], num_reg[j][95:94]};
            trial = {2'b0, root_reg[j], 2'b01};
            if (cur >= trial)
            begin
                rem_next[j] = 50'(cur - trial);
                bit_next[j] = 1'b1;
            end
            else
            begin
                rem_next[j] = cur[49:0];
                bit_next[j] = 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg[0]  <= (x > 64'sd0) ? ({32'b0, x} << FRAC_BITS) : '0;
        rem_reg[0]  <= '0;
        root_reg[0] <= '0;
        for (int j = 0; j < SQRT_STEPS; j++)
        begin
            num_reg[j+1]  <= num_reg[j] << 2;
            rem_reg[j+1]  <= rem_next[j];
            root_reg[j+1] <= {root_reg[j][SQRT_STEPS-2:0], bit_next[j]};
        end
    end

    assign r = $signed({16'b0, root_reg[SQRT_STEPS]});
endmodule

[rtl/mhd_signed_fast_wave_speed.sv]
// A result strobes on done once its cell has passed the input register, the unit pipeline and the output register.
// Throughput: one cell per cycle; busy stays low and results cannot be held off.
// Most of the depth comes from two 65-stage dividers and two 49-stage square-root units in series.
// Reset clears every valid bit in flight and loads gamma with five thirds.
// Top level of the fast magnetosonic wave speed pipeline.
`timescale 1ns / 1ps
module mhd_signed_fast_wave_speed #(
    parameter int FRAC_BITS  = mfws_pkg::FRAC_BITS_DEFAULT,
    parameter int WORD_WIDTH = mfws_pkg::WORD_WIDTH_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic signed [WORD_WIDTH-1:0]        density,
    input  logic signed [WORD_WIDTH-1:0]        momentum_x,
    input  logic signed [WORD_WIDTH-1:0]        momentum_y,
    input  logic signed [WORD_WIDTH-1:0]        momentum_z,
    input  logic signed [WORD_WIDTH-1:0]        total_energy,
    input  logic signed [WORD_WIDTH-1:0]        field_x,
    input  logic signed [WORD_WIDTH-1:0]        field_y,
    input  logic signed [WORD_WIDTH-1:0]        field_z,
    input  logic                                last_cell,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [mfws_pkg::GAMMA_WIDTH-1:0]    cfg_data,
    output logic                                done,
    output logic signed [WORD_WIDTH-1:0]        wave_speed,
    output logic                                invalid,
    output logic                                end_of_row
);
    import mfws_pkg::*;

    localparam logic signed [63:0] SMAX = (64'sd1 <<< (WORD_WIDTH - 1)) - 64'sd1;
    localparam logic signed [63:0] SMIN = -SMAX - 64'sd1;
    localparam logic signed [63:0] ONE  = 64'sd1 <<< FRAC_BITS;

    logic [GAMMA_WIDTH-1:0] gamma_reg;
    logic signed [63:0] gam, gm1;

    // input stage
    logic signed [63:0] rho_reg, mx_reg, my_reg, mz_reg, en_reg, bx_reg, by_reg, bz_reg;
    ctrl_t ctrl_reg, ctrl_next, ctrl_t13;

    logic signed [63:0] mxx, myy, mzz, bxx, byy, bzz;
    logic signed [63:0] m2_reg, b2_reg, bx2_reg;
    logic signed [63:0] rho_t2, mx_t2, rho_t6, en_t3, b2_t3;
    logic signed [63:0] m2rho, carho, b2rho, u_t3, b2rho_t7, ca_t8, u_t13;
    logic signed [63:0] eint_reg, pr, gp, cs2, cs2_reg, s_reg, s_t11;
    logic signed [63:0] ss, cc, arg_reg, inner, outer_reg, cfs;
    logic               pr_bad_t13;

    logic signed [63:0] plus, minus, speed, speed_sat;

    logic                         done_reg;
    logic signed [WORD_WIDTH-1:0] wave_speed_reg;
    logic                         invalid_reg, end_of_row_reg;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            gamma_reg <= GAMMA_RESET;
        else if (cfg_valid && cfg_ready)
            gamma_reg <= cfg_data;
    end

    assign gam = $signed({46'b0, gamma_reg});
    assign gm1 = gam - ONE;

    always_comb
    begin
        ctrl_next.valid   = start && !busy;
        ctrl_next.last    = last_cell;
        ctrl_next.rho_bad = (density <= WORD_WIDTH'(0));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ctrl_reg <= '0;
        else
            ctrl_reg <= ctrl_next;
    end

    always_ff @(posedge clk)
    begin
        rho_reg <= 64'(density);
        mx_reg  <= 64'(momentum_x);
        my_reg  <= 64'(momentum_y);
        mz_reg  <= 64'(momentum_z);
        en_reg  <= 64'(total_energy);
        bx_reg  <= 64'(field_x);
        by_reg  <= 64'(field_y);
        bz_reg  <= 64'(field_z);
    end

    // squares of momenta and field
    mfws_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_mx (.clk(clk), .a(mx_reg), .b(mx_reg), .p(mxx));
    mfws_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_my (.clk(clk), .a(my_reg), .b(my_reg), .p(myy));
    mfws_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_mz (.clk(clk), .a(mz_reg), .b(mz_reg), .p(mzz));
    mfws_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_bx (.clk(clk), .a(bx_reg), .b(bx_reg), .p(bxx));
    mfws_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_by (.clk(clk), .a(by_reg), .b(by_reg), .p(byy));
    mfws_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_bz (.clk(clk), .a(bz_reg), .b(bz_reg), .p(bzz));

    always_ff @(posedge clk)
    begin
        m2_reg  <= sadd(sadd(mxx, myy), mzz);
        b2_reg  <= sadd(sadd(bxx, byy), bzz);
        bx2_reg <= bxx;
    end

    mfws_delay #(.WIDTH(64), .DEPTH(T2 - T0)) u_dl_rho2 (.clk(clk), .rst_n(rst_n),
        .d(rho_reg), .q(rho_t2));
    mfws_delay #(.WIDTH(64), .DEPTH(T2 - T0)) u_dl_mx2 (.clk(clk), .rst_n(rst_n),
        .d(mx_reg), .q(mx_t2));
    mfws_delay #(.WIDTH(64), .DEPTH(T3 - T0)) u_dl_en3 (.clk(clk), .rst_n(rst_n),
        .d(en_reg), .q(en_t3));
    mfws_delay #(.WIDTH(64), .DEPTH(T3 - T2)) u_dl_b23 (.clk(clk), .rst_n(rst_n),
        .d(b2_reg), .q(b2_t3));
    mfws_delay #(.WIDTH(64), .DEPTH(T6 - T2)) u_dl_rho6 (.clk(clk), .rst_n(rst_n),
        .d(rho_t2), .q(rho_t6));

    mfws_div #(.FRAC_BITS(FRAC_BITS)) u_div_m2 (.clk(clk), .a(m2_reg), .b(rho_t2), .q(m2rho));
    mfws_div #(.FRAC_BITS(FRAC_BITS)) u_div_ca (.clk(clk), .a(bx2_reg), .b(rho_t2), .q(carho));
    mfws_div #(.FRAC_BITS(FRAC_BITS)) u_div_b2 (.clk(clk), .a(b2_reg), .b(rho_t2), .q(b2rho));
    mfws_div #(.FRAC_BITS(FRAC_BITS)) u_div_u (.clk(clk), .a(mx_t2), .b(rho_t2), .q(u_t3));

    always_ff @(posedge clk)
    begin
        eint_reg <= ssub(ssub(en_t3, half(m2rho)), half(b2_t3));
    end

    mfws_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_pr (.clk(clk), .a(gm1), .b(eint_reg), .p(pr));
    mfws_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_gp (.clk(clk), .a(gam), .b(pr), .p(gp));
    mfws_div #(.FRAC_BITS(FRAC_BITS)) u_div_cs (.clk(clk), .a(gp), .b(rho_t6), .q(cs2));

    mfws_delay #(.WIDTH(64), .DEPTH(T7 - T3)) u_dl_b2r (.clk(clk), .rst_n(rst_n),
        .d(b2rho), .q(b2rho_t7));
    mfws_delay #(.WIDTH(64), .DEPTH(T8 - T3)) u_dl_ca (.clk(clk), .rst_n(rst_n),
        .d(carho), .q(ca_t8));
    mfws_delay #(.WIDTH(64), .DEPTH(T13 - T3)) u_dl_u (.clk(clk), .rst_n(rst_n),
        .d(u_t3), .q(u_t13));

    always_ff @(posedge clk)
    begin
        s_reg   <= sadd(b2rho_t7, cs2);
        cs2_reg <= cs2;
    end

    mfws_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_ss (.clk(clk), .a(s_reg), .b(s_reg), .p(ss));
    mfws_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_cc (.clk(clk), .a(cs2_reg), .b(ca_t8), .p(cc));

    always_ff @(posedge clk)
    begin
        arg_reg <= ssub(ss, times4(cc));
    end

    // the root unit returns zero for a negative argument, which is the clamp
    mfws_sqrt #(.FRAC_BITS(FRAC_BITS)) u_sqrt_in (.clk(clk), .x(arg_reg), .r(inner));

    mfws_delay #(.WIDTH(64), .DEPTH(T11 - T8)) u_dl_s (.clk(clk), .rst_n(rst_n),
        .d(s_reg), .q(s_t11));

    always_ff @(posedge clk)
    begin
        outer_reg <= half(sadd(s_t11, inner));
    end

    mfws_sqrt #(.FRAC_BITS(FRAC_BITS)) u_sqrt_out (.clk(clk), .x(outer_reg), .r(cfs));

    mfws_delay #(.WIDTH($bits(ctrl_t)), .DEPTH(T13 - T0)) u_dl_ctrl (.clk(clk),
        .rst_n(rst_n), .d(ctrl_reg), .q(ctrl_t13));
    mfws_delay #(.WIDTH(1), .DEPTH(T13 - T5)) u_dl_prb (.clk(clk), .rst_n(rst_n),
        .d(pr[63]), .q(pr_bad_t13));

    always_comb
    begin
        plus  = sadd(u_t13, cfs);
        minus = ssub(u_t13, cfs);
        // on a magnitude tie take the minus branch
        speed = (mag64(plus) > mag64(minus)) ? plus : minus;
        if (speed > SMAX)
            speed_sat = SMAX;
        else if (speed < SMIN)
            speed_sat = SMIN;
        else
            speed_sat = speed;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= ctrl_t13.valid;
    end

    always_ff @(posedge clk)
    begin
        invalid_reg    <= ctrl_t13.rho_bad || pr_bad_t13;
        end_of_row_reg <= ctrl_t13.last;
        if (ctrl_t13.rho_bad || pr_bad_t13)
            wave_speed_reg <= '0;
        else
            wave_speed_reg <= speed_sat[WORD_WIDTH-1:0];
    end

    assign done       = done_reg;
    assign wave_speed = wave_speed_reg;
    assign invalid    = invalid_reg;
    assign end_of_row = end_of_row_reg;
endmodule

[rtl/mfws_checker.sv]
// Port-level checker for the fast wave speed pipeline, bound to the top level.
`timescale 1ns / 1ps
module mfws_checker #(
    parameter int WORD_WIDTH = mfws_pkg::WORD_WIDTH_DEFAULT
) (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         start,
    input logic                         busy,
    input logic signed [WORD_WIDTH-1:0] density,
    input logic                         last_cell,
    input logic                         done,
    input logic signed [WORD_WIDTH-1:0] wave_speed,
    input logic                         invalid,
    input logic                         end_of_row
);
    import mfws_pkg::*;

    localparam int LAT = T_OUT + 1;

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LAT done)
        else $error("accepted cell gave no result");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        !(start && !busy) |-> ##LAT !done)
        else $error("result without an accepted cell");

    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && invalid) |-> (wave_speed == '0))
        else $error("invalid result carries a speed");

    a_bad_density: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && density <= WORD_WIDTH'(0)) |-> ##LAT invalid)
        else $error("nonpositive density not flagged");

    a_row_marker: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (end_of_row == $past(last_cell, LAT)))
        else $error("end of row marker out of step");
endmodule

bind mhd_signed_fast_wave_speed mfws_checker #(.WORD_WIDTH(WORD_WIDTH)) u_mfws_checker (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .density(density),
    .last_cell(last_cell),
    .done(done),
    .wave_speed(wave_speed),
    .invalid(invalid),
    .end_of_row(end_of_row)
);

[tb/wave_speed_monitor.sv]
// Monitor and scoreboard for the fast wave speed block: predicts each cell result and compares.
`timescale 1ns / 1ps
module wave_speed_monitor (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic                              busy,
    input  logic signed [31:0]                density,
    input  logic signed [31:0]                momentum_x,
    input  logic signed [31:0]                momentum_y,
    input  logic signed [31:0]                momentum_z,
    input  logic signed [31:0]                total_energy,
    input  logic signed [31:0]                field_x,
    input  logic signed [31:0]                field_y,
    input  logic signed [31:0]                field_z,
    input  logic                              last_cell,
    input  logic                              cfg_valid,
    input  logic                              cfg_ready,
    input  logic [mfws_pkg::GAMMA_WIDTH-1:0]  cfg_data,
    input  logic                              done,
    input  logic signed [31:0]                wave_speed,
    input  logic                              invalid,
    input  logic                              end_of_row,
    output int                                fail_count,
    output int                                pending
);

    localparam logic signed [63:0] TOP = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam int FB = 16;

    typedef struct packed {
        logic signed [31:0] speed;
        logic               bad;
        logic               eor;
    } cell_result_t;

    cell_result_t speed_queue[$];
    logic [mfws_pkg::GAMMA_WIDTH-1:0] gamma_q;
    int mismatches;

    function automatic logic [63:0] absval(input logic signed [63:0] x);
        return x[63] ? 64'(-x) : 64'(x);
    endfunction

    function automatic logic signed [63:0] signed_of(input logic [63:0] m, input logic neg);
        logic [63:0] c;
        c = (m > 64'(TOP)) ? 64'(TOP) : m;
        return neg ? -$signed(c) : $signed(c);
    endfunction

    function automatic logic signed [63:0] sat_sum(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
        logic signed [64:0] s;
        s = {a[63], a} + {b[63], b};
        if (s > $signed({1'b0, TOP}))
            return TOP;
        if (s < -$signed({1'b0, TOP}))
            return -TOP;
        return s[63:0];
    endfunction

    function automatic logic signed [63:0] sat_diff(input logic signed [63:0] a,
                                                    input logic signed [63:0] b);
        return sat_sum(a, (b == {1'b1, 63'b0}) ? TOP : -b);
    endfunction

    function automatic logic signed [63:0] fx_mul(input logic signed [63:0] a,
                                                  input logic signed [63:0] b);
        logic [127:0] p;
        logic [63:0]  lo;
        p  = ({64'b0, absval(a)} * {64'b0, absval(b)}) >> FB;
        lo = (p[127:64] != 0) ? '1 : p[63:0];
        return signed_of(lo, a[63] ^ b[63]);
    endfunction

    function automatic logic signed [63:0] fx_div(input logic signed [63:0] a,
                                                  input logic signed [63:0] b);
        logic [127:0] q;
        logic [63:0]  lo;
        if (b == 0)
            return 0;
        q  = ({64'b0, absval(a)} << FB) / {64'b0, absval(b)};
        lo = (q[127:64] != 0) ? '1 : q[63:0];
        return signed_of(lo, a[63] ^ b[63]);
    endfunction

    function automatic logic signed [63:0] fx_root(input logic signed [63:0] x);
        logic [127:0] n;
        logic [63:0]  r, c;
        if (x <= 0)
            return 0;
        n = {64'b0, x} << FB;
        r = 0;
        for (int k = 47; k >= 0; k--)
        begin
            c = r | (64'd1 << k);
            if ({64'b0, c} * {64'b0, c} <= n)
                r = c;
        end
        return $signed(r);
    endfunction

    function automatic cell_result_t predict_speed(input logic signed [31:0] w[8],
                                                   input logic lc,
                                                   input logic [mfws_pkg::GAMMA_WIDTH-1:0] g);
        cell_result_t res;
        logic signed [63:0] rho, mx, my, mz, en, bx, by, bz, gam, m2, bx2, b2, eint, pr;
        logic signed [63:0] u, cs2, ca, s, p4, inner, cfs, plus, minus, spd;
        rho = w[0]; mx = w[1]; my = w[2]; mz = w[3];
        en = w[4]; bx = w[5]; by = w[6]; bz = w[7];
        res.speed = 0;
        res.bad   = 1'b0;
        res.eor   = lc;
        if (rho <= 0)
        begin
            res.bad = 1'b1;
            return res;
        end
        gam  = $signed({46'b0, g});
        m2   = sat_sum(sat_sum(fx_mul(mx, mx), fx_mul(my, my)), fx_mul(mz, mz));
        bx2  = fx_mul(bx, bx);
        b2   = sat_sum(sat_sum(bx2, fx_mul(by, by)), fx_mul(bz, bz));
        eint = sat_diff(sat_diff(en, fx_div(m2, rho) / 64'sd2), b2 / 64'sd2);
        pr   = fx_mul(gam - 64'sd65536, eint);
        if (pr < 0)
        begin
            res.bad = 1'b1;
            return res;
        end
        u     = fx_div(mx, rho);
        cs2   = fx_div(fx_mul(gam, pr), rho);
        ca    = fx_div(bx2, rho);
        s     = sat_sum(fx_div(b2, rho), cs2);
        p4    = fx_mul(cs2, ca);
        p4    = sat_sum(p4, p4);
        p4    = sat_sum(p4, p4);
        inner = fx_root(sat_diff(fx_mul(s, s), p4));
        cfs   = fx_root(sat_sum(s, inner) / 64'sd2);
        plus  = sat_sum(u, cfs);
        minus = sat_diff(u, cfs);
        spd   = (absval(plus) > absval(minus)) ? plus : minus;
        if (spd > 64'sd2147483647)
            spd = 64'sd2147483647;
        if (spd < -64'sd2147483648)
            spd = -64'sd2147483648;
        res.speed = spd[31:0];
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        cell_result_t exp_r;
        logic signed [31:0] w[8];
        if (!rst_n)
        begin
            gamma_q    <= mfws_pkg::GAMMA_RESET;
            speed_queue.delete();
            fail_count <= 0;
            mismatches = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                gamma_q <= cfg_data;
            if (start && !busy)
            begin
                w = '{density, momentum_x, momentum_y, momentum_z,
                      total_energy, field_x, field_y, field_z};
                speed_queue.push_back(predict_speed(w, last_cell, gamma_q));
            end
            if (done)
            begin
                if (speed_queue.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result: speed %0d invalid %b eor %b",
                                 wave_speed, invalid, end_of_row);
                end
                else
                begin
                    exp_r = speed_queue.pop_front();
                    if (exp_r.speed !== wave_speed || exp_r.bad !== invalid ||
                        exp_r.eor !== end_of_row)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: speed %0d/%0d invalid %b/%b eor %b/%b (exp/act)",
                                     exp_r.speed, wave_speed, exp_r.bad, invalid,
                                     exp_r.eor, end_of_row);
                    end
                end
            end
            fail_count <= mismatches;
        end
    end

    assign pending = speed_queue.size();

endmodule

[tb/testbench.sv]
// Top of the fast wave speed testbench: clock, reset, stimulus, watchdog and verdict.
`timescale 1ns / 1ps
module testbench;

    logic clk, rst_n, start, busy, last_cell, cfg_valid, cfg_ready;
    logic done, invalid, end_of_row;
    logic signed [31:0] density, momentum_x, momentum_y, momentum_z, total_energy;
    logic signed [31:0] field_x, field_y, field_z, wave_speed;
    logic [mfws_pkg::GAMMA_WIDTH-1:0] cfg_data;
    int fail_count, pending, quiet_cycles;
    bit calm;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int DRAIN_CYCLES   = 300;

    mhd_signed_fast_wave_speed DUT (.*);
    wave_speed_monitor monitor (.*);

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // count cycles with no transfer of any kind
    always @(posedge clk)
    begin
        if ((start && !busy) || done || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    task automatic maybe_idle();
        if (!calm && $urandom_range(99) < 6)
        begin
            start = 1'b0;
            @(negedge clk);
        end
    endtask

    task automatic send_cell(input logic [31:0] r, mx, my, mz, e, bx, by, bz,
                             input logic lc);
        logic was_busy;
        maybe_idle();
        density = r; momentum_x = mx; momentum_y = my; momentum_z = mz;
        total_energy = e; field_x = bx; field_y = by; field_z = bz;
        last_cell = lc;
        start = 1'b1;
        do
        begin
            was_busy = busy;
            @(posedge clk);
            @(negedge clk);
        end
        while (was_busy);
    endtask

    task automatic write_gamma(input logic [mfws_pkg::GAMMA_WIDTH-1:0] g);
        logic rdy;
        start = 1'b0;
        while (pending != 0)
            @(negedge clk);
        if (!calm && $urandom_range(99) < 6)
            @(negedge clk);
        cfg_data  = g;
        cfg_valid = 1'b1;
        do
        begin
            rdy = cfg_ready;
            @(posedge clk);
            @(negedge clk);
        end
        while (!rdy);
        cfg_valid = 1'b0;
    endtask

    task automatic random_cell();
        logic [31:0] r, v[7];
        if ($urandom_range(99) < 20)
        begin
            // raw words: any bit pattern
            r = $urandom();
            foreach (v[k])
                v[k] = $urandom();
        end
        else
        begin
            r = $urandom_range(32'd4096, 32'd100 << 16);
            for (int k = 0; k < 3; k++)
                v[k] = $signed($urandom_range(0, 1 << 23)) - (1 << 22);
            v[3] = ($urandom_range(99) < 10) ? $urandom_range(0, 1 << 16)
                                              : $urandom_range(1 << 20, 1 << 30);
            for (int k = 4; k < 7; k++)
                v[k] = $signed($urandom_range(0, 1 << 21)) - (1 << 20);
        end
        send_cell(r, v[0], v[1], v[2], v[3], v[4], v[5], v[6], 1'($urandom_range(0, 1)));
    endtask

    task automatic directed_cells();
        // nonpositive density, both zero and negative
        send_cell(32'd0, 32'd65536, 0, 0, 32'd65536, 0, 0, 0, 1'b0);
        send_cell(32'h8000_0000, 32'h7FFF_FFFF, 0, 0, 32'h7FFF_FFFF, 0, 0, 0, 1'b1);
        send_cell(32'hFFFF_0000, 0, 0, 0, 32'd65536, 0, 0, 0, 1'b0);
        // at rest with no field: magnitude tie picks the minus branch
        send_cell(32'd65536, 0, 0, 0, 32'd655360, 0, 0, 0, 1'b1);
        // moving cells, both directions
        send_cell(32'd65536, 32'd131072, 0, 0, 32'd655360, 32'd65536, 0, 0, 1'b0);
        send_cell(32'd131072, 32'hFFFC_0000, 32'd65536, 32'hFFFF_0000, 32'd1310720,
                  32'd32768, 32'hFFFF_8000, 32'd16384, 1'b0);
        // negative pressure: energy below kinetic part
        send_cell(32'd65536, 32'd655360, 0, 0, 32'd65536, 0, 0, 0, 1'b1);
        send_cell(32'd65536, 0, 0, 0, 32'h8000_0000, 0, 0, 0, 1'b0);
        // extremes: tiny density, huge momenta and fields drive saturation
        send_cell(32'd1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                  32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1);
        send_cell(32'd1, 32'h8000_0000, 0, 0, 32'h7FFF_FFFF, 0, 0, 0, 1'b0);
        send_cell(32'd1, 32'd1, 0, 0, 32'h7FFF_FFFF, 0, 0, 0, 1'b0);
        send_cell(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                  32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1);
        send_cell(32'h7FFF_FFFF, 0, 0, 0, 32'd1, 0, 0, 0, 1'b0);
        // strong field, weak gas: inner root argument near or below zero
        send_cell(32'd65536, 0, 0, 0, 32'd4194304, 32'd1048576, 32'd65536, 0, 1'b0);
        send_cell(32'd65536, 32'd65536, 0, 0, 32'd655360, 32'd262144, 0, 0, 1'b1);
    endtask

    initial
    begin
        rst_n = 1'b0; start = 1'b0; cfg_valid = 1'b0; cfg_data = '0;
        density = 0; momentum_x = 0; momentum_y = 0; momentum_z = 0;
        total_energy = 0; field_x = 0; field_y = 0; field_z = 0; last_cell = 1'b0;
        calm = 1'b0;
        quiet_cycles = 0;
        repeat (9) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        directed_cells();
        write_gamma(18'd65536);      // gamma one: pressure always zero
        directed_cells();
        write_gamma(18'h3FFFF);      // largest gamma
        directed_cells();
        write_gamma(18'd0);          // gamma below one: pressure sign flips
        directed_cells();
        write_gamma(18'd196608);
        for (int n = 0; n < 1600; n++)
        begin
            if (n % 400 == 399)
                write_gamma((n == 799) ? 18'd109227 : 18'($urandom_range(0, 18'h3FFFF)));
            calm = (n >= 1000 && n < 1300);
            random_cell();
        end
        start = 1'b0;

        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (fail_count == 0 && pending == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
